@@ hw/rtl/bdc_pkg.sv @@
// shared types, code formats and constants of the bitmask dictionary decompressor
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned DictN    = 8;
  localparam int unsigned DictIdxW = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned BufW     = 66;
  localparam int unsigned CntW     = 7;
  localparam int unsigned LenW     = 6;

  typedef enum logic [2:0] {
    FMT_REPEAT    = 3'b000,
    FMT_MASK4     = 3'b001,
    FMT_FLIP1     = 3'b010,
    FMT_FLIP2     = 3'b011,
    FMT_FLIP_PAIR = 3'b100,
    FMT_DIRECT    = 3'b101,
    FMT_RESERVED  = 3'b110,
    FMT_RAW       = 3'b111
  } bdc_fmt_e;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } bdc_state_e;

  typedef struct packed {
    logic [WordW-1:0] stream_word;
    logic             final_word;
  } bdc_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic             format_error;
    logic             run_last;
  } bdc_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic skip_word;
    logic emit;
    logic finish;
  } bdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic fits;
    logic last;
    logic out_free;
  } bdc_stat_t;

  // total code length, format included
  function automatic logic [LenW-1:0] code_len(input bdc_fmt_e fmt);
    logic [LenW-1:0] len;
    unique case (fmt)
      FMT_REPEAT:    len = LenW'(5);
      FMT_MASK4:     len = LenW'(15);
      FMT_FLIP1:     len = LenW'(11);
      FMT_FLIP2:     len = LenW'(11);
      FMT_FLIP_PAIR: len = LenW'(16);
      FMT_DIRECT:    len = LenW'(6);
      FMT_RESERVED:  len = LenW'(3);
      FMT_RAW:       len = LenW'(35);
      default:       len = LenW'(3);
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/bdc_if.sv @@
// request channels of the decompressor: compressed words in, decoded words out
`timescale 1ns / 1ps

interface bdc_in_if;
  import bdc_pkg::*;
  logic    valid;
  logic    ready;
  bdc_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bdc_out_if;
  import bdc_pkg::*;
  logic     valid;
  logic     ready;
  bdc_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/bdc_dict.sv @@
// eight-entry dictionary register file written through the configuration port
`timescale 1ns / 1ps

module bdc_dict
  import bdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_wdata_i,
  input  logic [DictIdxW-1:0] rd_addr_i,
  output logic [WordW-1:0]    rd_data_o
);

  logic [WordW-1:0] dict_q [DictN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DictN; i++) dict_q[i] <= '0;
    end else if (cfg_we_i && !cfg_idx_i[CfgIdxW-1]) begin
      // indices above the dictionary are ignored
      dict_q[cfg_idx_i[DictIdxW-1:0]] <= cfg_wdata_i;
    end
  end

  assign rd_data_o = dict_q[rd_addr_i];

endmodule

@@ hw/rtl/bdc_ctrl.sv @@
// controller: sequences word loads and one decoded result per cycle while the output register is free
`timescale 1ns / 1ps

module bdc_ctrl
  import bdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bdc_stat_t stat_i,
  output bdc_cmd_t  cmd_o
);

  bdc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stat_i.skip) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!stat_i.fits) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free && stat_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i && !stat_i.skip;
        cmd_o.skip_word = in_valid_i && stat_i.skip;
      end
      ST_DECODE: begin
        cmd_o.finish = !stat_i.fits;
        cmd_o.emit   = stat_i.fits && stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/bdc_datapath.sv @@
// datapath: bit buffer, code field extraction, word rebuild and output register
`timescale 1ns / 1ps

module bdc_datapath
  import bdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdc_cmd_t            cmd_i,
  output bdc_stat_t           stat_o,
  input  logic [WordW-1:0]    in_word_i,
  input  logic                in_final_i,
  output logic [DictIdxW-1:0] dict_addr_o,
  input  logic [WordW-1:0]    dict_word_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output bdc_out_t            out_data_o
);

  logic [BufW-1:0]  buf_q, buf_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] prev_q, prev_d;
  logic             skip_q, skip_d;
  logic             final_q, final_d;
  logic [1:0]       rep_q, rep_d;
  logic             out_valid_q, out_valid_d;
  bdc_out_t         out_q, out_d;

  bdc_fmt_e         fmt, fmt2;
  logic [LenW-1:0]  len, len2;
  logic [4:0]       pos_p, pos_q;
  logic [3:0]       mask;
  logic [WordW-1:0] res;
  logic [BufW-1:0]  shifted;
  logic [CntW-1:0]  cnt_next;
  logic             fits, fits2, rep_done, consume, last, out_free;

  // head of the buffer, oldest bit in the msb
  assign fmt   = bdc_fmt_e'(buf_q[BufW-1 -: 3]);
  assign len   = code_len(fmt);
  assign pos_p = buf_q[62:58];
  assign pos_q = buf_q[57:53];
  assign mask  = buf_q[57:54];

  assign fits = (cnt_q >= CntW'(3)) &&
                ((fmt == FMT_RESERVED) || ({1'b0, len} <= cnt_q));

  always_comb begin
    unique case (fmt)
      FMT_MASK4:                dict_addr_o = buf_q[53:51];
      FMT_FLIP1, FMT_FLIP2:     dict_addr_o = buf_q[57:55];
      FMT_FLIP_PAIR:            dict_addr_o = buf_q[52:50];
      default:                  dict_addr_o = buf_q[62:60];
    endcase
  end

  always_comb begin
    unique case (fmt)
      FMT_MASK4:     res = dict_word_i ^ ({mask, 28'b0} >> pos_p);
      FMT_FLIP1:     res = dict_word_i ^ (32'h8000_0000 >> pos_p);
      FMT_FLIP2:     res = dict_word_i ^ (32'hC000_0000 >> pos_p);
      FMT_FLIP_PAIR: res = dict_word_i ^ (32'h8000_0000 >> pos_p) ^ (32'h8000_0000 >> pos_q);
      FMT_DIRECT:    res = dict_word_i;
      FMT_RAW:       res = buf_q[62:31];
      FMT_REPEAT:    res = prev_q;
      default:       res = '0;
    endcase
  end

  assign rep_done = (rep_q == buf_q[62:61]);
  assign consume  = (fmt != FMT_RESERVED) && ((fmt != FMT_REPEAT) || rep_done);

  // look ahead at the code after this one to flag the last result of a word
  assign shifted  = buf_q << len;
  assign cnt_next = cnt_q - {1'b0, len};
  assign fmt2     = bdc_fmt_e'(shifted[BufW-1 -: 3]);
  assign len2     = code_len(fmt2);
  assign fits2    = (cnt_next >= CntW'(3)) &&
                    ((fmt2 == FMT_RESERVED) || ({1'b0, len2} <= cnt_next));
  assign last     = (fmt == FMT_RESERVED) || (consume && !fits2);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    skip_d      = skip_q;
    final_d     = final_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.load) begin
      buf_d   = buf_q | ({in_word_i, 34'b0} >> cnt_q);
      cnt_d   = cnt_q + CntW'(WordW);
      final_d = in_final_i;
    end

    if (cmd_i.skip_word && in_final_i) begin
      skip_d = 1'b0;
      buf_d  = '0;
      cnt_d  = '0;
    end

    if (cmd_i.finish && final_q) begin
      buf_d = '0;
      cnt_d = '0;
    end

    if (cmd_i.emit) begin
      out_valid_d        = 1'b1;
      out_d.out_word     = res;
      out_d.format_error = (fmt == FMT_RESERVED);
      out_d.run_last     = last;
      if (fmt == FMT_RESERVED) begin
        buf_d  = '0;
        cnt_d  = '0;
        skip_d = !final_q;
      end else if (consume) begin
        buf_d = shifted;
        cnt_d = cnt_next;
        rep_d = '0;
        if (fmt != FMT_REPEAT) prev_d = res;
      end else begin
        rep_d = rep_q + 2'd1;
      end
      // padding after the last code of a final word is dropped
      if (last && final_q) begin
        buf_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      skip_q      <= 1'b0;
      final_q     <= 1'b0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      skip_q      <= skip_d;
      final_q     <= final_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign stat_o.skip     = skip_q;
  assign stat_o.fits     = fits;
  assign stat_o.last     = last;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/bitmask_dictionary_code_decompressor.sv @@
// top level of the bitmask dictionary code decompressor with result checks
`timescale 1ns / 1ps

// Decodes a bitmask/dictionary compressed stream delivered as 32-bit words,
// first bit in bit 31. Codes open with a 3-bit format: repeat the previous
// word, xor a 4-bit mask, flip one, two adjacent or two given bits of a
// dictionary entry, a plain dictionary hit, or 32 raw bits; the reserved
// format gives one error result and the rest of the stream up to its final
// word is skipped. Up to 34 undecoded bits carry over to the next word, and
// the padding after the last code of a final word is dropped. The eight
// dictionary entries are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// (index 0..7, higher indices ignored); the user must write them only while
// the block is idle, the block itself does not enforce it. A word is loaded
// into the bit buffer, then the datapath's single decode step yields one
// result per cycle, each repeat counting as one, while the output register
// is free; a word with no result still enters the decode state, and a word
// skipped after an error is taken in without decoding. A result waits in
// the output register while the next word is already taken in; run_last
// marks the last result caused by a word.
module bitmask_dictionary_code_decompressor
  import bdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  bdc_in_if.sink             in_i,
  bdc_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i
);

  bdc_cmd_t            cmd;
  bdc_stat_t           stat;
  logic [DictIdxW-1:0] dict_addr;
  logic [WordW-1:0]    dict_word;

  // dictionary entries
  bdc_dict u_dict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_addr_i   (dict_addr),
    .rd_data_o   (dict_word)
  );

  // sequencing of loads and decode steps
  bdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // bit buffer, decode and output register
  bdc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_i.payload.stream_word),
    .in_final_i  (in_i.payload.final_word),
    .dict_addr_o (dict_addr),
    .dict_word_i (dict_word),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.payload)
  );

`ifndef NO_ASSERTIONS
  // an error result carries a zero word and closes the word's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.format_error) |->
      (out_o.payload.out_word == '0 && out_o.payload.run_last))
    else $error("error result with nonzero word or without run_last");

  // a decode step is only issued into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("decode step while output register is blocked");

  // a word is never loaded while results are still being decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && (cmd.emit || cmd.finish)))
    else $error("word load overlaps decode");

  // after a word is loaded the block does not take another one next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_i.ready)
    else $error("input taken again right after a load");
`endif

endmodule

@@ test/bitmask_dictionary_code_decompressor_test.sv @@
// self-checking bench for the bitmask dictionary decompressor: own decoder, random streams
`timescale 1ns / 1ps

module bitmask_dictionary_code_decompressor_test;
  import bdc_pkg::*;

  localparam int ClkPeriodNs   = 12;
  localparam int ResetCycles   = 8;
  localparam int SettleCycles  = 10;       // room for a word with no result to finish its decode step
  localparam int DrainGuard    = 150_000;  // per phase, far above the slowest legal drain
  localparam int TimeoutCycles = 600_000;
  localparam int HoldCycles    = 300;      // long receiver hold-off to back up the input
  localparam int WordsPerPhase = 32;

  // register map: dictionary entries at 0..7, everything above is unused
  localparam logic [CfgIdxW-1:0] DictIdxFirst   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] UnusedIdxFirst = CfgIdxW'(DictN);
  localparam logic [CfgIdxW-1:0] UnusedIdxLast  = {CfgIdxW{1'b1}};

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_wdata;

  bdc_in_if  req_in ();
  bdc_out_if req_out ();

  bitmask_dictionary_code_decompressor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (req_in),
    .out_o       (req_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // words waiting to be offered, and decoded words still to come out
  bdc_in_t  word_q[$];
  bdc_out_t expected_q[$];

  // bits of the stream under construction, oldest first
  bit code_bits[$];

  // decoder state kept by the bench
  logic [WordW-1:0] dict_copy [DictN] = '{default: '0};
  logic [WordW-1:0] dict_plan [DictN];
  logic [33:0]      held_bits  = '0;
  int               held_count = 0;
  logic [WordW-1:0] last_word  = '0;
  bit               skipping   = 1'b0;

  int       fails = 0;
  bit       calm  = 1'b0;   // no idling on either side in the closing phase
  bdc_out_t want_result;

  // driver and receiver pacing
  int send_gap      = 0;
  bit send_idling   = 1'b1;
  int stall_left    = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;
  bit recv_idling   = 1'b1;

  bdc_fmt_e legal_fmts [7] = '{FMT_REPEAT, FMT_MASK4, FMT_FLIP1, FMT_FLIP2,
                               FMT_FLIP_PAIR, FMT_DIRECT, FMT_RAW};

  initial begin
    clk = 1'b0;
    forever #(ClkPeriodNs / 2) clk = ~clk;
  end

  initial begin
    #(TimeoutCycles * ClkPeriodNs);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // decoder of the bench
  // ---------------------------------------------------------------------------

  // n bits from the joined stream, msb first; bits past the buffer read as 0
  function automatic logic [31:0] field(input bit [0:65] sb, input int at, input int n);
    logic [31:0] v;
    int i;
    v = '0;
    for (i = 0; i < n; i++) v = {v[30:0], (at + i < 66) ? sb[at + i] : 1'b0};
    return v;
  endfunction

  function automatic bdc_out_t make_result(input logic [WordW-1:0] w, input logic err);
    bdc_out_t r;
    r.out_word     = w;
    r.format_error = err;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // decode one accepted request and queue the words it must produce
  task automatic decode_word(input bdc_in_t item);
    bit [0:65]        sb;
    bdc_out_t         batch[$];
    bdc_fmt_e         fmt;
    logic [31:0]      tmp;
    logic [WordW-1:0] res;
    logic [4:0]       p, q;
    logic [3:0]       m;
    logic [2:0]       d;
    int               total, pos, len, reps, rem, i;
    // everything up to and including the final word is dropped after an error
    if (skipping) begin
      if (item.final_word) begin
        skipping   = 1'b0;
        held_bits  = '0;
        held_count = 0;
      end
      return;
    end
    sb = '0;
    for (i = 0; i < held_count; i++) sb[i] = held_bits[held_count - 1 - i];
    for (i = 0; i < 32; i++) sb[held_count + i] = item.stream_word[31 - i];
    total = held_count + 32;
    pos   = 0;
    while (total - pos >= 3) begin
      tmp = field(sb, pos, 3);
      fmt = bdc_fmt_e'(tmp[2:0]);
      if (fmt == FMT_RESERVED) begin
        batch.insert(batch.size(), make_result('0, 1'b1));
        pos = total;
        if (!item.final_word) skipping = 1'b1;
        break;
      end
      case (fmt)
        FMT_REPEAT:            len = 5;
        FMT_MASK4:             len = 15;
        FMT_FLIP1, FMT_FLIP2:  len = 11;
        FMT_FLIP_PAIR:         len = 16;
        FMT_DIRECT:            len = 6;
        default:               len = 35;
      endcase
      if (len > total - pos) break;
      res = '0;
      case (fmt)
        FMT_REPEAT: begin
          reps = int'(field(sb, pos + 3, 2)) + 1;
          repeat (reps) batch.insert(batch.size(), make_result(last_word, 1'b0));
        end
        FMT_MASK4: begin
          p = 5'(field(sb, pos + 3, 5));
          m = 4'(field(sb, pos + 8, 4));
          d = 3'(field(sb, pos + 12, 3));
          // mask bits shifted past bit 0 fall off
          res = dict_copy[d] ^ ({m, 28'd0} >> p);
        end
        FMT_FLIP1: begin
          p = 5'(field(sb, pos + 3, 5));
          d = 3'(field(sb, pos + 8, 3));
          res = dict_copy[d] ^ (32'h8000_0000 >> p);
        end
        FMT_FLIP2: begin
          p = 5'(field(sb, pos + 3, 5));
          d = 3'(field(sb, pos + 8, 3));
          res = dict_copy[d] ^ (32'hC000_0000 >> p);
        end
        FMT_FLIP_PAIR: begin
          p = 5'(field(sb, pos + 3, 5));
          q = 5'(field(sb, pos + 8, 5));
          d = 3'(field(sb, pos + 13, 3));
          // equal positions cancel
          res = dict_copy[d] ^ (32'h8000_0000 >> p) ^ (32'h8000_0000 >> q);
        end
        FMT_DIRECT: begin
          d   = 3'(field(sb, pos + 3, 3));
          res = dict_copy[d];
        end
        default: res = field(sb, pos + 3, 32);
      endcase
      if (fmt != FMT_REPEAT) begin
        last_word = res;
        batch.insert(batch.size(), make_result(res, 1'b0));
      end
      pos += len;
    end
    if (item.final_word) begin
      // padding after the last code is thrown away
      held_bits  = '0;
      held_count = 0;
      skipping   = 1'b0;
    end else begin
      rem = total - pos;
      if (rem > 34) rem = 34;
      held_bits = '0;
      for (i = 0; i < rem; i++) held_bits = {held_bits[32:0], sb[total - rem + i]};
      held_count = rem;
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    for (i = 0; i < batch.size(); i++) expected_q.insert(expected_q.size(), batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stream construction
  // ---------------------------------------------------------------------------

  task automatic put_bits(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) code_bits.insert(code_bits.size(), v[i]);
  endtask

  // for the repeat format p carries the run count minus one
  task automatic add_code(input bdc_fmt_e fmt, input logic [4:0] p, input logic [4:0] q,
                          input logic [3:0] m, input logic [2:0] d, input logic [31:0] raw);
    put_bits(32'(fmt), 3);
    case (fmt)
      FMT_REPEAT:            put_bits(32'(p[1:0]), 2);
      FMT_MASK4:             begin
        put_bits(32'(p), 5); put_bits(32'(m), 4); put_bits(32'(d), 3);
      end
      FMT_FLIP1, FMT_FLIP2:  begin put_bits(32'(p), 5); put_bits(32'(d), 3); end
      FMT_FLIP_PAIR:         begin
        put_bits(32'(p), 5); put_bits(32'(q), 5); put_bits(32'(d), 3);
      end
      FMT_DIRECT:            put_bits(32'(d), 3);
      FMT_RAW:               put_bits(raw, 32);
      default:               ;
    endcase
  endtask

  task automatic add_random_code();
    add_code(legal_fmts[$urandom_range(0, 6)], 5'($urandom_range(0, 31)),
             5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
             3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic push_word(input logic [WordW-1:0] w, input logic fin);
    bdc_in_t item;
    item.stream_word = w;
    item.final_word  = fin;
    word_q.insert(word_q.size(), item);
  endtask

  // pad to a word boundary and cut into requests, the last one marked final
  task automatic close_stream(input bit pad_random);
    logic [WordW-1:0] w;
    int i;
    if (code_bits.size() == 0) put_bits('1, 32);
    while (code_bits.size() % 32 != 0)
      code_bits.insert(code_bits.size(), pad_random ? 1'($urandom_range(0, 1)) : 1'b1);
    while (code_bits.size() > 0) begin
      for (i = 0; i < 32; i++) w[31 - i] = code_bits.pop_front();
      push_word(w, code_bits.size() == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // configuration and phase control
  // ---------------------------------------------------------------------------

  // writes dict_plan, then one write to an unused index that must change nothing
  task automatic load_dictionary();
    int i;
    for (i = 0; i < DictN; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= DictIdxFirst + CfgIdxW'(i);
      cfg_wdata <= dict_plan[i];
      dict_copy[i] = dict_plan[i];
    end
    @(posedge clk);
    cfg_idx   <= CfgIdxW'($urandom_range(UnusedIdxFirst, UnusedIdxLast));
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the queued requests to go in and every expected word to come out
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((word_q.size() != 0 || req_in.valid || expected_q.size() != 0)
           && guard < DrainGuard) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DrainGuard) begin
      $display("%0t: drain timed out, %0d words queued, %0d results still expected",
               $time, word_q.size(), expected_q.size());
      fails++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_phase();
    int roll, n, k, i;
    while (word_q.size() < WordsPerPhase) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        // noise words, most of them stop at a reserved format sooner or later
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) push_word($urandom, i == k - 1);
      end else begin
        n = $urandom_range(2, 24);
        for (i = 0; i < n; i++) add_random_code();
        // broken stream: reserved format with junk behind it
        if (roll < 4) begin
          put_bits(32'(FMT_RESERVED), 3);
          put_bits($urandom, 32);
        end
        close_stream($urandom_range(0, 3) == 0);
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // repeat before any word was decoded, dictionary still at reset
    add_code(FMT_REPEAT, 5'd3, '0, '0, '0, '0);
    add_code(FMT_DIRECT, '0, '0, '0, 3'd5, '0);
    close_stream(1'b0);
    wait_drained();

    dict_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h8000_0001, 32'h7FFF_FFFE, 32'h0001_0000, 32'hDEAD_BEEF};
    load_dictionary();

    // every legal format, with the mask and position edges
    for (i = 0; i < DictN; i++) add_code(FMT_DIRECT, '0, '0, '0, 3'(i), '0);
    add_code(FMT_MASK4, 5'd0, '0, 4'hF, 3'd0, '0);
    add_code(FMT_MASK4, 5'd28, '0, 4'hF, 3'd0, '0);
    add_code(FMT_MASK4, 5'd29, '0, 4'hF, 3'd0, '0);   // mask runs off bit 0
    add_code(FMT_MASK4, 5'd31, '0, 4'hF, 3'd1, '0);
    add_code(FMT_MASK4, 5'd13, '0, 4'h9, 3'd7, '0);
    add_code(FMT_FLIP1, 5'd0, '0, '0, 3'd0, '0);
    add_code(FMT_FLIP1, 5'd31, '0, '0, 3'd1, '0);
    add_code(FMT_FLIP2, 5'd0, '0, '0, 3'd0, '0);
    add_code(FMT_FLIP2, 5'd30, '0, '0, 3'd0, '0);
    add_code(FMT_FLIP2, 5'd31, '0, '0, 3'd0, '0);      // second bit dropped
    add_code(FMT_FLIP_PAIR, 5'd3, 5'd3, '0, 3'd2, '0);  // same bit twice, no change
    add_code(FMT_FLIP_PAIR, 5'd0, 5'd31, '0, 3'd0, '0);
    add_code(FMT_FLIP_PAIR, 5'd31, 5'd0, '0, 3'd1, '0);
    add_code(FMT_RAW, '0, '0, '0, '0, 32'hFFFF_FFFF);
    add_code(FMT_RAW, '0, '0, '0, '0, 32'h0000_0000);
    add_code(FMT_RAW, '0, '0, '0, '0, 32'h8000_0001);
    add_code(FMT_REPEAT, 5'd0, '0, '0, '0, '0);
    add_code(FMT_REPEAT, 5'd3, '0, '0, '0, '0);
    close_stream(1'b0);

    // all-zero words: single repeats back to back with bits carried over
    push_word('0, 1'b0);
    push_word('0, 1'b0);
    push_word('0, 1'b1);

    // reserved format mid-stream, the two words after it must stay silent
    add_code(FMT_DIRECT, '0, '0, '0, 3'd3, '0);
    put_bits(32'(FMT_RESERVED), 3);
    put_bits($urandom, 32);
    put_bits($urandom, 32);
    close_stream(1'b1);
    // decoding resumes after the skipped final word
    add_code(FMT_DIRECT, '0, '0, '0, 3'd4, '0);
    add_code(FMT_FLIP1, 5'd17, '0, '0, 3'd6, '0);
    close_stream(1'b0);

    // reserved format inside the final word itself
    add_code(FMT_DIRECT, '0, '0, '0, 3'd1, '0);
    put_bits(32'(FMT_RESERVED), 3);
    close_stream(1'b1);

    // raw word straddling three requests, 34 bits held in between
    for (i = 0; i < 5; i++) add_code(FMT_DIRECT, '0, '0, '0, 3'(i), '0);
    add_code(FMT_RAW, '0, '0, '0, '0, 32'hC3C3_C3C3);
    add_code(FMT_REPEAT, 5'd1, '0, '0, '0, '0);
    close_stream(1'b0);

    // final word holding only an unfinished raw code: no result at all
    push_word(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // random phases over several dictionaries
    for (i = 0; i < DictN; i++) dict_plan[i] = $urandom;
    load_dictionary();
    random_phase();

    for (i = 0; i < DictN; i++) dict_plan[i] = '1;
    load_dictionary();
    random_phase();

    for (i = 0; i < DictN; i++) dict_plan[i] = i[0] ? $urandom : 32'h0;
    load_dictionary();
    calm = 1'b1;
    random_phase();

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request driver: offers queued words, predicts on every accepted one
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_in.valid   <= 1'b0;
      req_in.payload <= '0;
      send_gap = 0;
    end else begin
      if (req_in.valid && req_in.ready) decode_word(req_in.payload);
      if (req_in.valid && !req_in.ready) begin
        // request not taken yet, keep it up
      end else if (send_gap > 0) begin
        send_gap--;
        req_in.valid <= 1'b0;
      end else if (!calm && send_idling && $urandom_range(0, 5) == 0) begin
        // idle now and for a random gap after
        send_gap = $urandom_range(0, 13);
        req_in.valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        req_in.payload <= word_q.pop_front();
        req_in.valid   <= 1'b1;
      end else begin
        req_in.valid <= 1'b0;
      end
      // switch between stretches with and without idling
      if ($urandom_range(0, 39) == 0) send_idling = !send_idling;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_out.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        req_out.ready <= 1'b0;
      end else if (!pressure_done && req_out.valid && word_q.size() > 4) begin
        // plenty still to send: hold off so the block backs up its input
        pressure_done = 1'b1;
        hold_left = HoldCycles - 1;
        req_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        req_out.ready <= 1'b0;
      end else if (!calm && recv_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        req_out.ready <= 1'b0;
      end else begin
        req_out.ready <= 1'b1;
      end
      if ($urandom_range(0, 39) == 0) recv_idling = !recv_idling;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && req_out.valid && req_out.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, req_out.payload.out_word);
      end else begin
        want_result = expected_q.pop_front();
        if (req_out.payload.out_word !== want_result.out_word)
          report_mismatch("out_word", want_result.out_word, req_out.payload.out_word);
        if (req_out.payload.format_error !== want_result.format_error)
          report_mismatch("format_error", 32'(want_result.format_error),
                          32'(req_out.payload.format_error));
        if (req_out.payload.run_last !== want_result.run_last)
          report_mismatch("run_last", 32'(want_result.run_last),
                          32'(req_out.payload.run_last));
      end
    end
  end

endmodule
